// ===== hdl/mfv_pkg.sv =====
// Package for the most frequent value finder.
// Holds the default store depth, the controller state type and the
// command and status groups shared by the controller and datapath.
package mfv_pkg;

  parameter int unsigned MFV_DEPTH_DEFAULT = 256;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_LATCH,
    S_SWEEP,
    S_DRAIN,
    S_UPDATE,
    S_OUT
  } mfv_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store;        // write the accepted request into the store
    logic search_init;  // restart candidate index and best count
    logic cand_rd;      // read the candidate entry
    logic cand_ld;      // capture candidate, restart sweep and tally
    logic sweep_rd;     // read the sweep entry, advance sweep index
    logic update;       // fold tally into best, advance candidate index
    logic out_ld;       // load result register, start a new set
  } mfv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_j;       // sweep index is on the final stored entry
    logic last_i;       // candidate index is on the final stored entry
  } mfv_status_t;

endpackage

// ===== hdl/mfv_ctrl.sv =====
// Controller for the most frequent value finder.
// Sequences load, pairwise count and result hand-off; depends on mfv_pkg.
module mfv_ctrl
  import mfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output mfv_cmd_t    cmd,
  input  mfv_status_t status
);

  mfv_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_LOAD);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_LOAD: begin
        cmd.store = accept;
        if (accept && in_last) begin
          cmd.search_init = 1'b1;
          state_nxt       = S_RD_I;
        end
      end
      S_RD_I: begin
        cmd.cand_rd = 1'b1;
        state_nxt   = S_LATCH;
      end
      S_LATCH: begin
        cmd.cand_ld = 1'b1;
        state_nxt   = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (status.last_j) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = status.last_i ? S_OUT : S_RD_I;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

// ===== hdl/mfv_datapath.sv =====
// Datapath for the most frequent value finder.
// Element store, indexes, tally, best tracking and result register; uses mfv_pkg.
module mfv_datapath
  import mfv_pkg::*;
#(
  parameter int unsigned DEPTH = MFV_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  input  mfv_cmd_t           cmd,
  output mfv_status_t        status,
  output logic signed [31:0] out_mode_value,
  output logic               out_overflow
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_r;
  logic [31:0]   cand_r;
  logic [31:0]   best_val_r;
  logic [CW-1:0] fill_r;
  logic          drop_r;
  logic [AW-1:0] i_r;
  logic [AW-1:0] j_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] best_cnt_r;
  logic          cmp_en_r;
  logic [31:0]   mode_r;
  logic          ovf_r;

  logic          full;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign full  = (fill_r == DEPTH_C);
  // The closing request always lands; when full it takes the top entry
  assign wr_en = cmd.store && (!full || in_last);
  assign waddr = full ? TOP_ADDR : fill_r[AW-1:0];
  assign raddr = cmd.sweep_rd ? j_r : i_r;

  assign status.last_j = ((CW'(j_r) + CW'(1)) == fill_r);
  assign status.last_i = ((CW'(i_r) + CW'(1)) == fill_r);

  assign out_mode_value = mode_r;
  assign out_overflow   = ovf_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= in_value;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      drop_r     <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      cnt_r      <= '0;
      best_cnt_r <= '0;
      cmp_en_r   <= 1'b0;
    end else begin
      cmp_en_r <= cmd.sweep_rd;
      if (cmd.out_ld) begin
        fill_r <= '0;
        drop_r <= 1'b0;
      end else if (cmd.store) begin
        if (full) begin
          drop_r <= 1'b1;
        end else begin
          fill_r <= fill_r + CW'(1);
        end
      end
      if (cmd.search_init) begin
        i_r        <= '0;
        best_cnt_r <= '0;
      end else if (cmd.update) begin
        i_r <= i_r + AW'(1);
        if (cnt_r > best_cnt_r) begin
          best_cnt_r <= cnt_r;
        end
      end
      if (cmd.cand_ld) begin
        j_r   <= '0;
        cnt_r <= '0;
      end else begin
        if (cmd.sweep_rd) begin
          j_r <= j_r + AW'(1);
        end
        if (cmp_en_r && (rdata_r == cand_r)) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_ld) begin
      cand_r <= rdata_r;
    end
    if (cmd.update && (cnt_r > best_cnt_r)) begin
      best_val_r <= cand_r;
    end
    if (cmd.out_ld) begin
      mode_r <= best_val_r;
      ovf_r  <= drop_r;
    end
  end

endmodule

// ===== hdl/most_frequent_value_finder.sv =====
// Top level of the most frequent value finder.
// Joins mfv_ctrl and mfv_datapath; depends on mfv_pkg.
//
// Usage:
//   Input requests carry in_value (signed 32 bits) and in_last. A request is
//   taken on a clock edge with in_valid high and in_stall low. Requests fill
//   an element store of DEPTH entries, one per cycle while in_stall is low, with no extra cost.
//   Requests beyond DEPTH are dropped and remembered; the request flagged
//   last is always stored (into the top entry when the store is full).
//   The last request starts the search: each stored entry in turn is read as
//   a candidate and the whole set is swept over the single store read port
//   to tally matches. The earliest candidate with the strictly highest tally
//   wins. Each candidate steps through S_RD_I, S_LATCH, a sweep of every entry,
//   S_DRAIN and S_UPDATE; S_OUT then loads the result register.
//   The result leaves as out_mode_value with out_overflow set when requests
//   were dropped. It is held in the output register while out_stall is high;
//   loading of the next set goes on meanwhile, and a following search waits
//   only for that register to empty. After the result the set starts empty.
//   Reset (rst_n low, synchronous) empties the set, clears the drop flag and
//   clears out_valid. No clearing pass is needed.
module most_frequent_value_finder
  import mfv_pkg::*;
#(
  parameter int unsigned DEPTH = MFV_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_mode_value,
  output logic               out_overflow
);

  mfv_cmd_t    cmd;
  mfv_status_t status;

  // Controller: accepts requests, walks candidate and sweep, hands off result
  mfv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: store, tally and best tracking, result register
  mfv_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_last        (in_last),
    .cmd            (cmd),
    .status         (status),
    .out_mode_value (out_mode_value),
    .out_overflow   (out_overflow)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for most_frequent_value_finder.
// Holds its own mode predictor, request driver and result monitor.
// Depends on mfv_pkg for the store depth; needs only the RTL.
module testbench;
  import mfv_pkg::*;

  localparam int unsigned DEPTH       = MFV_DEPTH_DEFAULT;
  // The longest search (full store) runs with no handshake at all; the limit
  // allows several times its length before giving up.
  localparam int unsigned QUIET_LIMIT = 4 * DEPTH * (DEPTH + 4) + 20000;
  localparam int unsigned DRAIN_WAIT  = 64;
  localparam int unsigned PHASE_ITEMS = 262;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
  } element_req_t;

  typedef struct {
    logic signed [31:0] mode_value;
    logic               overflow;
  } mode_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_mode_value;
  logic               out_overflow;

  // Request queue filled by the sequence below, drained by the driver.
  element_req_t pending_q[$];
  // Expected mode results, oldest first.
  mode_result_t mode_expect_q[$];

  // Predictor state: a private copy of the element store and set status.
  logic signed [31:0] elem_mem [DEPTH];
  int unsigned        fill_cnt = 0;
  logic               set_dropped = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned elements_taken = 0;
  int unsigned sets_queued = 0;
  int unsigned overflow_sets = 0;
  int unsigned largest_set = 0;

  most_frequent_value_finder #(
    .DEPTH(DEPTH)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mode_value(out_mode_value),
    .out_overflow  (out_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Fold one accepted request into the predictor. A request past the end of
  // the store is dropped, except the last one, which replaces the top entry.
  // Closing the set searches for the earliest value with the strictly
  // highest count and queues it as the expected result.
  function automatic void absorb_element(input logic signed [31:0] value,
                                         input logic last);
    mode_result_t res;
    int unsigned  tally;
    int unsigned  best_tally;
    int unsigned  best_pos;
    if (fill_cnt < DEPTH) begin
      elem_mem[fill_cnt] = value;
      fill_cnt++;
    end else begin
      if (last) elem_mem[DEPTH-1] = value;
      set_dropped = 1'b1;
    end
    if (last) begin
      best_tally = 0;
      best_pos = 0;
      for (int i = 0; i < fill_cnt; i++) begin
        tally = 0;
        for (int j = 0; j < fill_cnt; j++) begin
          if (elem_mem[j] == elem_mem[i]) tally++;
        end
        // strict compare: earlier candidates keep ties
        if (tally > best_tally) begin
          best_tally = tally;
          best_pos = i;
        end
      end
      res.mode_value = elem_mem[best_pos];
      res.overflow = set_dropped;
      if (set_dropped) overflow_sets++;
      mode_expect_q.push_back(res);
      fill_cnt = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // Driver: advance to the next request once the current one is taken or
  // none is on the bus; hold the request steady while it is stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      in_last <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        absorb_element(in_value, in_last);
        elements_taken++;
        void'(pending_q.pop_front());
      end
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_value <= pending_q[0].value;
        in_last <= pending_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation,
  // then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mode_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: unexpected result mode=%0d overflow=%0b",
                     out_mode_value, out_overflow);
        end else begin
          if (out_mode_value !== mode_expect_q[0].mode_value ||
              out_overflow !== mode_expect_q[0].overflow) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("ERROR: result %0d expected mode=%0d overflow=%0b, got mode=%0d overflow=%0b",
                       results_checked, mode_expect_q[0].mode_value,
                       mode_expect_q[0].overflow, out_mode_value, out_overflow);
          end
          void'(mode_expect_q.pop_front());
        end
        results_checked++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void push_element(input logic signed [31:0] value,
                                       input logic last);
    element_req_t req;
    req.value = value;
    req.last = last;
    pending_q.push_back(req);
    if (last) sets_queued++;
  endfunction

  // Mostly full-range random values, with the corners mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      4:       return $signed($urandom_range(15)) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  // Queue one set of n elements. Most sets draw from a small pool so that
  // values repeat and counts compete; the rest are fully random noise.
  function automatic void add_random_set(input int unsigned n);
    logic signed [31:0] pool [8];
    int unsigned        pool_size;
    logic signed [31:0] value;
    pool_size = $urandom_range(1, 8);
    for (int k = 0; k < 8; k++) pool[k] = pick_value();
    if ($urandom_range(9) >= 7) pool_size = 0;
    for (int k = 0; k < n; k++) begin
      if (pool_size == 0) value = pick_value();
      else value = pool[$urandom_range(pool_size - 1)];
      push_element(value, k == n - 1);
    end
    if (n > largest_set) largest_set = n;
  endfunction

  // Fill up to the phase budget with small sets, then wait until every
  // request is taken and every result has been checked.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned budget);
    int unsigned queued;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queued = pending_q.size();
    while (queued < budget) begin
      int unsigned n;
      n = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 24);
      add_random_set(n);
      queued += n;
    end
    while (pending_q.size() != 0 || mode_expect_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned big_n;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sets: single-element sets at both extremes.
    push_element(32'sh8000_0000, 1'b1);
    push_element(32'sh7fff_ffff, 1'b1);
    // Tie between the two extremes: the earlier one wins.
    push_element(32'sh7fff_ffff, 1'b0);
    push_element(32'sh8000_0000, 1'b0);
    push_element(32'sh8000_0000, 1'b0);
    push_element(32'sh7fff_ffff, 1'b1);
    // All distinct: the first element wins.
    push_element(32'sd1, 1'b0);
    push_element(32'sd2, 1'b0);
    push_element(-32'sd3, 1'b1);
    // A later value with a strictly higher count replaces the first.
    push_element(32'sd9, 1'b0);
    push_element(32'sd4, 1'b0);
    push_element(32'sd4, 1'b0);
    push_element(32'sd4, 1'b0);
    push_element(32'sd9, 1'b1);
    // All equal.
    push_element(-32'sd1, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(-32'sd1, 1'b1);
    // All zeros against all ones.
    push_element(32'sd0, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(32'sd0, 1'b1);

    // Phase: no idling on either side.
    run_phase(0, 0, PHASE_ITEMS);

    // Phase: sender idle often. Lead with a set one past the store depth:
    // the last element replaces the top entry and overflow is flagged.
    add_random_set(DEPTH + 1);
    run_phase(58, 0, PHASE_ITEMS);

    // Phase: receiver stalls often. Lead with a set around the full store,
    // exactly full at the low end, dropping elements above it.
    big_n = $urandom_range(DEPTH, DEPTH + 8);
    add_random_set(big_n);
    run_phase(0, 58, PHASE_ITEMS);

    // Phase: light idling on both sides.
    run_phase(11, 11, PHASE_ITEMS);

    // Let any stray result show up before judging.
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d elements in %0d sets (largest %0d, %0d with dropped elements)",
             elements_taken, sets_queued, largest_set, overflow_sets);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && mode_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
